### rtl/ptc_pkg.sv
package ptc_pkg;

    localparam int unsigned COEFF_W   = 16;
    localparam int unsigned RAW_W     = 24;
    localparam int unsigned TEMP_W    = 19;
    localparam int unsigned PRESS_W   = 32;
    localparam int unsigned S_DATA_W  = 48;
    localparam int unsigned M_DATA_W  = 56;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned N_STAGE   = 12;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SENS        = 3'd0,
        CFG_OFFSET      = 3'd1,
        CFG_SENS_TEMP   = 3'd2,
        CFG_OFFSET_TEMP = 3'd3,
        CFG_REF_TEMP    = 3'd4,
        CFG_TEMP_SLOPE  = 3'd5,
        CFG_VARIANT     = 3'd6
    } t_cfg_idx;

    localparam logic [TEMP_W-1:0] TEMP_BASE      = 19'd2000;
    localparam logic [TEMP_W-1:0] VLOW_OFFSET    = 19'd3500;
    localparam logic signed [TEMP_W-1:0] VLOW_DT = -19'sd3600;

    localparam logic [31:0] RECIP_10  = 32'hCCCC_CCCD;
    localparam logic [31:0] RECIP_100 = 32'h51EB_851F;

endpackage

### rtl/pressure_temperature_compensation.sv
// Each accepted input transaction passes through the twelve register stages to the master side.
// Throughput: one transaction per cycle while the master side is ready, set by the twelve-stage register pipeline;
// each stage holds only while its successor is full and stalled.
// Reset (synchronous, active low): clears all calibration coefficients and the variant
// to zero and empties the pipeline.
module pressure_temperature_compensation
    import ptc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [COEFF_W-1:0]   i_cfg_wdata,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_DATA_W-1:0]  s_axis_tdata,   // raw_pressure[23:0], raw_temperature[47:24]
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_DATA_W-1:0]  m_axis_tdata    // temperature_centi[18:0], pressure_mbar[50:19]
);

    logic [COEFF_W-1:0] r_c1, r_c2, r_c3, r_c4, r_c5, r_c6;
    logic               r_var;

    logic [N_STAGE:1] r_vld;
    logic [N_STAGE:1] w_en;
    logic [N_STAGE:1] w_vin;

    // stage 1
    logic [RAW_W-1:0]  r1_d1;
    logic signed [24:0] r1_dt, n1_dt;
    // stage 2
    logic [RAW_W-1:0]   r2_d1;
    logic signed [41:0] r2_pt, r2_ps, r2_po, n2_pt, n2_ps, n2_po;
    logic signed [49:0] n2_sqf;
    logic [47:0]        r2_sq;
    // stage 3
    logic [RAW_W-1:0]    r3_d1;
    logic signed [18:0]  r3_dtemp, n3_dtemp;
    logic [TEMP_W-1:0]   r3_temp;
    logic [35:0]         r3_sens, n3_sens, n3_psq;
    logic [36:0]         r3_off, n3_off, n3_poq;
    logic [16:0]         r3_t3, r3_t11, n3_t3, n3_t11;
    logic [11:0]         r3_t2;
    logic [49:0]         n3_sq3;
    logic [51:0]         n3_sq11;
    // stage 4
    logic [RAW_W-1:0]   r4_d1;
    logic [35:0]        r4_sens;
    logic [36:0]        r4_off;
    logic [TEMP_W-1:0]  r4_temp, n4_temp;
    logic [16:0]        n4_ti;
    logic signed [18:0] n4_e;
    logic signed [37:0] n4_dsqf, n4_esqf;
    logic [34:0]        r4_dsq, r4_esq;
    logic               r4_low, r4_vlow;
    // stage 5
    logic [RAW_W-1:0]  r5_d1;
    logic [35:0]       r5_sens;
    logic [36:0]       r5_off;
    logic [TEMP_W-1:0] r5_temp;
    logic [39:0]       r5_offi, r5_sensi, n5_offi, n5_sensi;
    logic [41:0]       n5_d3, n5_d31, n5_d5, n5_d63, n5_e7, n5_e4;
    // stage 6
    logic [RAW_W-1:0]  r6_d1;
    logic [TEMP_W-1:0] r6_temp;
    logic [39:0]       r6_sens2, r6_off2;
    // stage 7
    logic [TEMP_W-1:0]  r7_temp;
    logic [39:0]        r7_off2;
    logic [43:0]        r7_pplo;
    logic signed [44:0] r7_pphi;
    // stage 8
    logic [TEMP_W-1:0] r8_temp;
    logic [39:0]       r8_off2;
    logic [63:0]       r8_prod;
    // stage 9
    logic [TEMP_W-1:0] r9_temp;
    logic [44:0]       r9_r, n9_r;
    // stage 10
    logic [TEMP_W-1:0] r10_temp;
    logic              r10_neg;
    logic [43:0]       r10_mag;
    // stage 11
    logic [TEMP_W-1:0] r11_temp;
    logic              r11_neg;
    logic [63:0]       r11_prod;
    logic [31:0]       n11_m, n11_k;
    // stage 12
    logic [TEMP_W-1:0]  r12_temp;
    logic [PRESS_W-1:0] r12_press, n12_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1  <= '0;
            r_c2  <= '0;
            r_c3  <= '0;
            r_c4  <= '0;
            r_c5  <= '0;
            r_c6  <= '0;
            r_var <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_SENS:        r_c1  <= i_cfg_wdata;
                CFG_OFFSET:      r_c2  <= i_cfg_wdata;
                CFG_SENS_TEMP:   r_c3  <= i_cfg_wdata;
                CFG_OFFSET_TEMP: r_c4  <= i_cfg_wdata;
                CFG_REF_TEMP:    r_c5  <= i_cfg_wdata;
                CFG_TEMP_SLOPE:  r_c6  <= i_cfg_wdata;
                CFG_VARIANT:     r_var <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // advance a stage when it is empty or its successor advances
    always_comb begin
        w_en[N_STAGE] = !r_vld[N_STAGE] || m_axis_tready;
        for (int k = N_STAGE - 1; k >= 1; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign w_vin         = {r_vld[N_STAGE-1:1], s_axis_tvalid};
    assign s_axis_tready = w_en[1];
    assign m_axis_tvalid = r_vld[N_STAGE];
    assign m_axis_tdata  = {5'b0, r12_press, r12_temp};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 1; k <= N_STAGE; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= w_vin[k];
                end
            end
        end
    end

    // stage 1: temperature difference
    assign n1_dt = $signed({1'b0, s_axis_tdata[47:24]}) - $signed({1'b0, r_c5, 8'h00});

    // stage 2: products against dT
    assign n2_pt  = r1_dt * $signed({1'b0, r_c6});
    assign n2_ps  = r1_dt * $signed({1'b0, r_c3});
    assign n2_po  = r1_dt * $signed({1'b0, r_c4});
    assign n2_sqf = r1_dt * r1_dt;

    // stage 3: first-order terms, truncating toward zero
    always_comb begin
        n3_dtemp = r2_pt[41:23] + {18'b0, (r2_pt[41] && (|r2_pt[22:0]))};
        if (r_var) begin
            n3_psq = {r2_ps[41], r2_ps[41:7]} + {35'b0, (r2_ps[41] && (|r2_ps[6:0]))};
            n3_poq = {r2_po[41], r2_po[41:6]} + {36'b0, (r2_po[41] && (|r2_po[5:0]))};
            n3_sens = n3_psq + {4'b0, r_c1, 16'b0};
            n3_off  = n3_poq + {4'b0, r_c2, 17'b0};
        end else begin
            n3_psq = {{2{r2_ps[41]}}, r2_ps[41:8]}
                   + {35'b0, (r2_ps[41] && (|r2_ps[7:0]))};
            n3_poq = {{2{r2_po[41]}}, r2_po[41:7]}
                   + {36'b0, (r2_po[41] && (|r2_po[6:0]))};
            n3_sens = n3_psq + {5'b0, r_c1, 15'b0};
            n3_off  = n3_poq + {5'b0, r_c2, 16'b0};
        end
        n3_sq3  = {2'b0, r2_sq} + {1'b0, r2_sq, 1'b0};
        n3_sq11 = {1'b0, r2_sq, 3'b0} + {3'b0, r2_sq, 1'b0} + {4'b0, r2_sq};
        n3_t3   = n3_sq3[49:33];
        n3_t11  = n3_sq11[51:35];
    end

    // stage 4: temperature correction and squares of the temperature offsets
    always_comb begin
        n4_e = r3_dtemp + $signed(VLOW_OFFSET);
        if (r3_dtemp[18]) begin
            n4_ti = r_var ? r3_t11 : r3_t3;
        end else begin
            n4_ti = r_var ? 17'd0 : {5'b0, r3_t2};
        end
        n4_temp = r3_temp - {2'b0, n4_ti};
        n4_dsqf = r3_dtemp * r3_dtemp;
        n4_esqf = n4_e * n4_e;
    end

    // stage 5: second-order offset and sensitivity terms
    always_comb begin
        n5_d3  = {7'b0, r4_dsq} + {6'b0, r4_dsq, 1'b0};
        n5_d31 = {2'b0, r4_dsq, 5'b0} - {7'b0, r4_dsq};
        n5_d5  = {5'b0, r4_dsq, 2'b0} + {7'b0, r4_dsq};
        n5_d63 = {1'b0, r4_dsq, 6'b0} - {7'b0, r4_dsq};
        n5_e7  = r4_vlow ? ({4'b0, r4_esq, 3'b0} - {7'b0, r4_esq}) : 42'd0;
        n5_e4  = r4_vlow ? {5'b0, r4_esq, 2'b0} : 42'd0;
        case ({r_var, r4_low})
            2'b01: begin
                n5_offi  = n5_d3[40:1] + n5_e7[39:0];
                n5_sensi = {1'b0, n5_d5[41:3]} + n5_e4[39:0];
            end
            2'b11: begin
                n5_offi  = {1'b0, n5_d31[41:3]};
                n5_sensi = {3'b0, n5_d63[41:5]};
            end
            2'b00: begin
                n5_offi  = {9'b0, r4_dsq[34:4]};
                n5_sensi = '0;
            end
            default: begin
                n5_offi  = '0;
                n5_sensi = '0;
            end
        endcase
    end

    // stage 9: truncate by 2^21 and remove the offset
    always_comb begin
        n9_r = {{2{r8_prod[63]}}, r8_prod[63:21]}
             + {44'b0, (r8_prod[63] && (|r8_prod[20:0]))}
             - {{5{r8_off2[39]}}, r8_off2};
    end

    // stage 11: scale and divide by 10 or 100 through a reciprocal
    always_comb begin
        n11_m = r_var ? {3'b0, r10_mag[43:15]} : {1'b0, r10_mag[43:13]};
        n11_k = r_var ? RECIP_100 : RECIP_10;
    end

    // stage 12: restore the sign
    always_comb begin
        n12_q = r_var ? {5'b0, r11_prod[63:37]} : {3'b0, r11_prod[63:35]};
        if (r11_neg) begin
            n12_q = -n12_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r1_d1 <= s_axis_tdata[23:0];
            r1_dt <= n1_dt;
        end
        if (w_en[2]) begin
            r2_d1 <= r1_d1;
            r2_pt <= n2_pt;
            r2_ps <= n2_ps;
            r2_po <= n2_po;
            r2_sq <= n2_sqf[47:0];
        end
        if (w_en[3]) begin
            r3_d1    <= r2_d1;
            r3_dtemp <= n3_dtemp;
            r3_temp  <= n3_dtemp + TEMP_BASE;
            r3_sens  <= n3_sens;
            r3_off   <= n3_off;
            r3_t3    <= n3_t3;
            r3_t11   <= n3_t11;
            r3_t2    <= r2_sq[47:36];
        end
        if (w_en[4]) begin
            r4_d1   <= r3_d1;
            r4_sens <= r3_sens;
            r4_off  <= r3_off;
            r4_temp <= n4_temp;
            r4_dsq  <= n4_dsqf[34:0];
            r4_esq  <= n4_esqf[34:0];
            r4_low  <= r3_dtemp[18];
            r4_vlow <= (r3_dtemp <= VLOW_DT);
        end
        if (w_en[5]) begin
            r5_d1    <= r4_d1;
            r5_sens  <= r4_sens;
            r5_off   <= r4_off;
            r5_temp  <= r4_temp;
            r5_offi  <= n5_offi;
            r5_sensi <= n5_sensi;
        end
        if (w_en[6]) begin
            r6_d1    <= r5_d1;
            r6_temp  <= r5_temp;
            r6_sens2 <= {{4{r5_sens[35]}}, r5_sens} - r5_sensi;
            r6_off2  <= {{3{r5_off[36]}}, r5_off} - r5_offi;
        end
        if (w_en[7]) begin
            r7_temp <= r6_temp;
            r7_off2 <= r6_off2;
            r7_pplo <= r6_d1 * r6_sens2[19:0];
            r7_pphi <= $signed({1'b0, r6_d1}) * $signed(r6_sens2[39:20]);
        end
        if (w_en[8]) begin
            r8_temp <= r7_temp;
            r8_off2 <= r7_off2;
            r8_prod <= {r7_pphi[43:0], 20'b0} + {20'b0, r7_pplo};
        end
        if (w_en[9]) begin
            r9_temp <= r8_temp;
            r9_r    <= n9_r;
        end
        if (w_en[10]) begin
            r10_temp <= r9_temp;
            r10_neg  <= r9_r[44];
            r10_mag  <= r9_r[44] ? (44'd0 - r9_r[43:0]) : r9_r[43:0];
        end
        if (w_en[11]) begin
            r11_temp <= r10_temp;
            r11_neg  <= r10_neg;
            r11_prod <= n11_m * n11_k;
        end
        if (w_en[12]) begin
            r12_temp  <= r11_temp;
            r12_press <= n12_q;
        end
    end

endmodule

### verif/tb_pressure_temperature_compensation.sv
module tb_pressure_temperature_compensation
    import ptc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned LONG_HOLD_CYCLES = 60;
    localparam int unsigned DRAIN_LIMIT      = 5000;
    localparam int unsigned SETTLE_CYCLES    = N_STAGE + 4;
    localparam int unsigned RANDOM_SETS      = 12;
    localparam int unsigned ITEMS_PER_SET    = 58;
    localparam int unsigned PRESSURE_ITEMS   = 40;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

    localparam longint SCALE_2P33 = 64'sd8589934592;
    localparam longint SCALE_2P35 = 64'sd34359738368;
    localparam longint SCALE_2P37 = 64'sd137438953472;
    localparam longint PRESS_MAX  = 64'sd2147483647;
    localparam longint PRESS_MIN  = -64'sd2147483648;

    typedef enum logic [1:0] {
        BAND_WARM,
        BAND_COLD,
        BAND_VERY_COLD
    } t_band;

    typedef enum logic [1:0] {
        SINK_READY,
        SINK_RANDOM,
        SINK_SPARSE,
        SINK_PERIODIC
    } t_sink_mode;

    typedef struct {
        logic signed [TEMP_W-1:0]  temperature_centi;
        logic signed [PRESS_W-1:0] pressure_mbar;
        t_band                     band;
    } t_reading;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_addr;
    logic [COEFF_W-1:0]   i_cfg_wdata;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_DATA_W-1:0]  s_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_DATA_W-1:0]  m_axis_tdata;

    logic [COEFF_W-1:0] cal_sens;
    logic [COEFF_W-1:0] cal_offset;
    logic [COEFF_W-1:0] cal_sens_temp;
    logic [COEFF_W-1:0] cal_offset_temp;
    logic [COEFF_W-1:0] cal_ref_temp;
    logic [COEFF_W-1:0] cal_temp_slope;
    logic               cal_variant;

    t_reading expected_readings[$];

    logic        hold_request = 1'b0;
    logic        gaps_enabled = 1'b1;
    int unsigned burst_left   = 0;

    int unsigned error_count        = 0;
    int unsigned samples_accepted   = 0;
    int unsigned results_checked    = 0;
    int unsigned calib_sets         = 0;
    int unsigned input_stall_cycles = 0;
    int unsigned band_count[3]      = '{0, 0, 0};
    int unsigned variant_count[2]   = '{0, 0};

    pressure_temperature_compensation i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("[pressure_temperature_compensation] ERROR");
        $finish;
    end

    function automatic t_reading compensate_reading(input logic [RAW_W-1:0] raw_p,
                                                    input logic [RAW_W-1:0] raw_t);
        t_reading r;
        longint d1, d2, c1, c2, c3, c4, c5, c6;
        longint dt, sens, off, temp, dtemp, ti, offi, sensi, e, p;
        d1 = longint'(raw_p);
        d2 = longint'(raw_t);
        c1 = longint'(cal_sens);
        c2 = longint'(cal_offset);
        c3 = longint'(cal_sens_temp);
        c4 = longint'(cal_offset_temp);
        c5 = longint'(cal_ref_temp);
        c6 = longint'(cal_temp_slope);
        ti = 0;
        offi = 0;
        sensi = 0;
        r.band = BAND_WARM;

        dt = d2 - c5 * 256;
        if (cal_variant) begin
            sens = c1 * 65536 + (c3 * dt) / 128;
            off  = c2 * 131072 + (c4 * dt) / 64;
        end else begin
            sens = c1 * 32768 + (c3 * dt) / 256;
            off  = c2 * 65536 + (c4 * dt) / 128;
        end
        temp  = 2000 + (dt * c6) / 8388608;
        dtemp = temp - 2000;

        if (temp < 2000) begin
            r.band = BAND_COLD;
            if (cal_variant) begin
                ti    = (11 * dt * dt) / SCALE_2P35;
                offi  = (31 * dtemp * dtemp) / 8;
                sensi = (63 * dtemp * dtemp) / 32;
            end else begin
                ti    = (3 * dt * dt) / SCALE_2P33;
                offi  = (3 * dtemp * dtemp) / 2;
                sensi = (5 * dtemp * dtemp) / 8;
                if (temp <= -1600) begin
                    r.band = BAND_VERY_COLD;
                    e = temp + 1500;
                    offi  = offi + 7 * e * e;
                    sensi = sensi + 4 * e * e;
                end
            end
        end else if (!cal_variant) begin
            ti   = (2 * dt * dt) / SCALE_2P37;
            offi = (dtemp * dtemp) / 16;
        end

        sens = sens - sensi;
        off  = off - offi;
        temp = temp - ti;

        if (cal_variant)
            p = (((d1 * sens) / 2097152 - off) / 32768) / 100;
        else
            p = (((d1 * sens) / 2097152 - off) / 8192) / 10;
        if (p > PRESS_MAX)
            p = PRESS_MAX;
        if (p < PRESS_MIN)
            p = PRESS_MIN;

        r.temperature_centi = temp[TEMP_W-1:0];
        r.pressure_mbar     = p[PRESS_W-1:0];
        return r;
    endfunction

    function automatic logic [RAW_W-1:0] saturate_raw(input longint v);
        if (v < 0)
            return '0;
        if (v > longint'(24'hFFFFFF))
            return '1;
        return v[RAW_W-1:0];
    endfunction

    function automatic logic [COEFF_W-1:0] pick_coeff();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return COEFF_W'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        error_count++;
    endtask

    always @(posedge i_clk) begin : check_results
        t_reading                  want;
        logic signed [TEMP_W-1:0]  got_temp;
        logic signed [PRESS_W-1:0] got_press;
        if (i_rst_n) begin
            if (s_axis_tvalid && !s_axis_tready)
                input_stall_cycles++;
            if (m_axis_tvalid && m_axis_tready) begin
                got_temp  = m_axis_tdata[TEMP_W-1:0];
                got_press = m_axis_tdata[TEMP_W+PRESS_W-1:TEMP_W];
                if (expected_readings.size() == 0) begin
                    report_mismatch($sformatf("result with nothing pending: temp %0d press %0d",
                                              got_temp, got_press));
                end else begin
                    want = expected_readings.pop_front();
                    results_checked++;
                    if (got_temp !== want.temperature_centi)
                        report_mismatch($sformatf("temperature_centi got %0d want %0d",
                                                  got_temp, want.temperature_centi));
                    if (got_press !== want.pressure_mbar)
                        report_mismatch($sformatf("pressure_mbar got %0d want %0d",
                                                  got_press, want.pressure_mbar));
                end
            end
        end
    end

    initial begin : drive_sink
        t_sink_mode  mode;
        int unsigned seg_left;
        int unsigned hold_left;
        int unsigned phase;
        mode = SINK_READY;
        seg_left = 0;
        hold_left = 0;
        phase = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            phase++;
            if (hold_left == 0 && hold_request) begin
                hold_left = LONG_HOLD_CYCLES;
                hold_request <= 1'b0;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                if (seg_left == 0) begin
                    mode = t_sink_mode'($urandom_range(0, 3));
                    seg_left = $urandom_range(16, 160);
                end
                seg_left--;
                case (mode)
                    SINK_READY:  m_axis_tready <= 1'b1;
                    SINK_RANDOM: m_axis_tready <= 1'($urandom_range(0, 1));
                    SINK_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default:     m_axis_tready <= ((phase % 5) < 3);
                endcase
            end
        end
    end

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [COEFF_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        case (idx)
            CFG_SENS:        cal_sens        = value;
            CFG_OFFSET:      cal_offset      = value;
            CFG_SENS_TEMP:   cal_sens_temp   = value;
            CFG_OFFSET_TEMP: cal_offset_temp = value;
            CFG_REF_TEMP:    cal_ref_temp    = value;
            CFG_TEMP_SLOPE:  cal_temp_slope  = value;
            CFG_VARIANT:     cal_variant     = value[0];
            default: ;
        endcase
    endtask

    task automatic load_calibration(input logic [COEFF_W-1:0] c1, c2, c3, c4, c5, c6,
                                    input logic variant);
        write_register(CFG_SENS, c1);
        write_register(CFG_OFFSET, c2);
        write_register(CFG_SENS_TEMP, c3);
        write_register(CFG_OFFSET_TEMP, c4);
        write_register(CFG_REF_TEMP, c5);
        write_register(CFG_TEMP_SLOPE, c6);
        write_register(CFG_VARIANT, {{(COEFF_W-1){1'b0}}, variant});
        i_cfg_we <= 1'b0;
        calib_sets++;
    endtask

    task automatic load_random_calibration();
        load_calibration(pick_coeff(), pick_coeff(), pick_coeff(), pick_coeff(),
                         pick_coeff(), pick_coeff(), 1'($urandom_range(0, 1)));
    endtask

    task automatic send_sample(input logic [RAW_W-1:0] raw_p, input logic [RAW_W-1:0] raw_t);
        t_reading    want;
        int unsigned gap;
        if (burst_left == 0) begin
            if (gaps_enabled) begin
                gap = $urandom_range(1, 6);
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_axis_tdata  <= {raw_t, raw_p};
        s_axis_tvalid <= 1'b1;
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        want = compensate_reading(raw_p, raw_t);
        expected_readings.push_back(want);
        samples_accepted++;
        band_count[want.band]++;
        variant_count[cal_variant]++;
    endtask

    task automatic send_random_sample();
        logic [RAW_W-1:0] raw_p;
        logic [RAW_W-1:0] raw_t;
        longint           centre;
        case ($urandom_range(0, 7))
            0:       raw_p = '0;
            1:       raw_p = '1;
            default: raw_p = RAW_W'($urandom_range(0, 24'hFFFFFF));
        endcase
        centre = longint'(cal_ref_temp) * 256;
        // bias towards the reference point so the 20 degC boundary is crossed often
        case ($urandom_range(0, 5))
            0:       raw_t = {RAW_W{1'($urandom_range(0, 1))}};
            1, 2:    raw_t = saturate_raw(centre + longint'($urandom_range(0, 4000)) - 2000);
            3:       raw_t = saturate_raw(centre - longint'($urandom_range(0, 24'hFFFFFF)));
            default: raw_t = RAW_W'($urandom_range(0, 24'hFFFFFF));
        endcase
        send_sample(raw_p, raw_t);
    endtask

    task automatic wait_until_drained();
        int unsigned waited;
        waited = 0;
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (expected_readings.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_readings.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", expected_readings.size()));
            expected_readings.delete();
        end
    endtask

    task automatic test_reset_calibration();
        send_sample('0, '0);
        send_sample('1, '0);
        send_sample('0, '1);
        send_sample('1, '1);
    endtask

    task automatic test_full_scale();
        wait_until_drained();
        load_calibration('1, '1, '1, '1, '1, '1, 1'b0);
        send_sample('0, '0);
        send_sample('1, '1);
        wait_until_drained();
        write_register(CFG_VARIANT, 16'h0001);
        i_cfg_we <= 1'b0;
        send_sample('0, '1);
        send_sample('1, '0);
    endtask

    task automatic test_temperature_bands();
        // edges around -16.00 degC and 20.00 degC with reference 2^23 and slope 2^15
        logic [RAW_W-1:0] band_edges[7] = '{24'd7466752, 24'd7467008, 24'd7467264,
                                            24'd8388352, 24'd8388607, 24'd8388608,
                                            24'd8388864};
        wait_until_drained();
        load_calibration(16'd40000, 16'd36000, 16'd23000, 16'd21000, 16'h8000, 16'h8000, 1'b0);
        foreach (band_edges[k])
            send_sample(RAW_W'($urandom_range(0, 24'hFFFFFF)), band_edges[k]);
        wait_until_drained();
        write_register(CFG_VARIANT, 16'h0001);
        i_cfg_we <= 1'b0;
        for (int k = 3; k < 7; k++)
            send_sample(RAW_W'($urandom_range(0, 24'hFFFFFF)), band_edges[k]);
    endtask

    task automatic test_register_decode();
        wait_until_drained();
        write_register(CFG_UNUSED_IDX, 16'hFFFF);
        write_register(CFG_VARIANT, 16'hFFFE);
        i_cfg_we <= 1'b0;
        send_sample(24'hA5A5A5, 24'h800000);
        send_sample(24'h5A5A5A, 24'h7F0000);
    endtask

    task automatic test_random_calibration();
        for (int set = 0; set < RANDOM_SETS; set++) begin
            wait_until_drained();
            load_random_calibration();
            gaps_enabled = ($urandom_range(0, 3) != 0);
            repeat (ITEMS_PER_SET) send_random_sample();
        end
    endtask

    task automatic test_output_backpressure();
        wait_until_drained();
        load_random_calibration();
        gaps_enabled = 1'b0;
        hold_request <= 1'b1;
        repeat (PRESSURE_ITEMS) send_random_sample();
        gaps_enabled = 1'b1;
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_addr      = '0;
        i_cfg_wdata     = '0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        cal_sens        = '0;
        cal_offset      = '0;
        cal_sens_temp   = '0;
        cal_offset_temp = '0;
        cal_ref_temp    = '0;
        cal_temp_slope  = '0;
        cal_variant     = 1'b0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_calibration();
        test_full_scale();
        test_temperature_bands();
        test_register_decode();
        test_random_calibration();
        test_output_backpressure();
        wait_until_drained();

        $display("Checked %0d of %0d samples over %0d calibration sets (%0d high, %0d low)",
                 results_checked, samples_accepted, calib_sets,
                 variant_count[0], variant_count[1]);
        $display("Bands: %0d warm, %0d cold, %0d very cold; %0d input stall cycles",
                 band_count[BAND_WARM], band_count[BAND_COLD], band_count[BAND_VERY_COLD],
                 input_stall_cycles);
        if (error_count == 0)
            $display("[pressure_temperature_compensation] OK");
        else
            $display("[pressure_temperature_compensation] ERROR");
        $finish;
    end

endmodule

### pressure_temperature_compensation.f
rtl/ptc_pkg.sv
rtl/pressure_temperature_compensation.sv
verif/tb_pressure_temperature_compensation.sv
